>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file cht_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define CHT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define CHT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> rtl/core/cht_pkg.sv
// Package for the checkpoint height table: opcodes, status codes, types.
// No dependencies.
package cht_pkg;
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_BELOW  = 3'd2;
  localparam logic [2:0] OP_PREV   = 3'd3;
  localparam logic [2:0] OP_COVER  = 3'd4;
  localparam logic [2:0] OP_SETL   = 3'd5;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;
  localparam logic [15:0] WINDOW_MASK = 16'hffff;
  typedef struct packed {
    logic [31:0] ch;
    logic [31:0] nh;
    logic [31:0] wd;
    logic        hr;
  } entry_t;
endpackage

>>> rtl/core/cht_cell.sv
// One entry cell of the checkpoint chain: holds an entry, loads it on append, shifts it along.
// Depends on cht_pkg.
module cht_cell (
  input  logic            clk,
  input  logic            shift,
  input  logic            load,
  input  cht_pkg::entry_t d_in,
  input  cht_pkg::entry_t ld_in,
  output cht_pkg::entry_t q_out
);
  cht_pkg::entry_t ent_r;
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= ld_in;
    end else if (shift) begin
      ent_r <= d_in;
    end
  end
  assign q_out = ent_r;
endmodule

>>> rtl/core/checkpoint_height_table_unit.sv
// Checkpoint height table: entries live in a ring of cells that rotates by one per scan cycle.
// Clear, append, set last, unused opcodes and a previous-root query answered from the last
// record (when it has a root) pass from idle through the done state to a registered result;
// the next start is accepted in the result cycle. Other lookups first scan one full rotation
// of the ring. One command at a time; the result cannot be stalled. Synchronous active-low
// reset clears count, hint and last record; table entries are undefined until written.
module checkpoint_height_table_unit #(
  parameter int MAX_CHECKPOINTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic signed [31:0] in_chain_height,
  input  logic signed [31:0] in_notarized_height,
  input  logic signed [31:0] in_window_depth,
  input  logic        in_has_root,
  input  logic signed [31:0] in_query_height,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_entry_index,
  output logic signed [31:0] out_height_result,
  output logic [8:0]  out_entry_count
);
  localparam int N = MAX_CHECKPOINTS;
  localparam int CW = $clog2(N + 1);
  localparam int PW = (N > 1) ? $clog2(N) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r;
  logic [CW-1:0] count_r;
  logic [7:0] hint_r;
  logic [31:0] last_nh_r, last_wd_r;
  logic last_hr_r;
  logic [2:0] op_r;
  logic signed [31:0] q_r;
  logic [CW-1:0] step_r;
  logic [1:0] st_r;
  logic [7:0] idx_r;
  logic [31:0] hgt_r;
  logic found_r, stop_r;
  logic [7:0] hit_r, hthint_r, fhint_r;
  logic [31:0] hit_nh_r, hitf_nh_r;
  logic fhit_any_r;
  logic [7:0] fhit_r;
  logic hint_ok_r;

  cht_pkg::entry_t chain [N];
  cht_pkg::entry_t feed;
  cht_pkg::entry_t head;
  cht_pkg::entry_t wr_ent;
  logic shift;
  logic app_ok;
  logic do_wr;
  logic [PW-1:0] wpos;
  logic [PW-1:0] pos;

  assign app_ok = (count_r < CW'(N));
  assign wpos = count_r[PW-1:0];
  assign do_wr = start && (state_r == S_IDLE) && (in_opcode == cht_pkg::OP_APPEND) && app_ok;
  assign wr_ent = '{ch: in_chain_height, nh: in_notarized_height,
                    wd: in_window_depth, hr: in_has_root};
  assign shift = (state_r == S_SCAN);
  assign head = chain[0];
  assign feed = head;
  assign pos = step_r[PW-1:0];

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      if (g == N - 1) begin : g_last
        cht_cell u_cell (.clk(clk), .shift(shift), .load(do_wr && (wpos == PW'(g))),
                         .d_in(feed), .ld_in(wr_ent), .q_out(chain[g]));
      end else begin : g_mid
        cht_cell u_cell (.clk(clk), .shift(shift), .load(do_wr && (wpos == PW'(g))),
                         .d_in(chain[g+1]), .ld_in(wr_ent), .q_out(chain[g]));
      end
    end
  endgenerate

  logic signed [32:0] e_s, lo_s, q_s;
  assign e_s = 33'(signed'(head.nh));
  assign lo_s = e_s - 33'({1'b0, head.wd[15:0] & cht_pkg::WINDOW_MASK});
  assign q_s = 33'(q_r);
  logic in_tab;
  assign in_tab = (CW'(pos) < count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      hint_r <= '0;
      last_nh_r <= '0;
      last_wd_r <= '0;
      last_hr_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r <= in_opcode;
            q_r <= in_query_height;
            st_r <= cht_pkg::ST_OK;
            idx_r <= '0;
            hgt_r <= '0;
            step_r <= '0;
            fhit_any_r <= 1'b0;
            found_r <= 1'b0;
            stop_r <= 1'b0;
            hthint_r <= hint_r;
            fhint_r <= hint_r;
            hint_ok_r <= 1'b0;
            state_r <= S_DONE;
            case (in_opcode)
              cht_pkg::OP_CLEAR: count_r <= '0;
              cht_pkg::OP_APPEND: begin
                last_nh_r <= in_notarized_height;
                last_wd_r <= in_window_depth;
                last_hr_r <= in_has_root;
                if (app_ok) begin
                  idx_r <= 8'(count_r);
                  count_r <= count_r + CW'(1);
                end else begin
                  st_r <= cht_pkg::ST_FULL;
                end
              end
              cht_pkg::OP_SETL: last_nh_r <= in_notarized_height;
              cht_pkg::OP_BELOW, cht_pkg::OP_COVER: begin
                st_r <= cht_pkg::ST_NONE;
                state_r <= S_SCAN;
              end
              cht_pkg::OP_PREV: begin
                if (last_hr_r) begin
                  hgt_r <= last_nh_r;
                end else begin
                  st_r <= cht_pkg::ST_NONE;
                  state_r <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          step_r <= step_r + CW'(1);
          if (in_tab) begin
            case (op_r)
              cht_pkg::OP_PREV: begin
                if (head.hr) begin
                  st_r <= cht_pkg::ST_OK;
                  idx_r <= 8'(pos);
                  hgt_r <= head.nh;
                end
              end
              cht_pkg::OP_COVER: begin
                if (head.wd != 32'd0 && q_s > lo_s && q_s <= e_s) begin
                  st_r <= cht_pkg::ST_OK;
                  idx_r <= 8'(pos);
                  hgt_r <= head.nh;
                end
              end
              default: begin
                if (!stop_r) begin
                  if (signed'(head.ch) >= q_r) begin
                    stop_r <= 1'b1;
                  end else begin
                    fhit_any_r <= 1'b1;
                    fhit_r <= 8'(pos);
                    hitf_nh_r <= head.nh;
                    fhint_r <= 8'(pos);
                  end
                end
                if (hint_r != 8'd0 && CW'(hint_r) < count_r) begin
                  if (CW'(pos) + CW'(1) == CW'(hint_r)) begin
                    hint_ok_r <= signed'(head.ch) < q_r;
                    hit_r <= 8'(pos);
                    hit_nh_r <= head.nh;
                  end else if (CW'(pos) >= CW'(hint_r) && hint_ok_r && !found_r) begin
                    if (signed'(head.ch) >= q_r) begin
                      found_r <= 1'b1;
                    end else begin
                      hit_r <= 8'(pos);
                      hit_nh_r <= head.nh;
                      hthint_r <= 8'(pos);
                    end
                  end
                end
              end
            endcase
          end
          if (step_r == CW'(N - 1)) begin
            state_r <= S_DONE;
          end
        end
        default: begin
          if (op_r == cht_pkg::OP_BELOW) begin
            if (found_r) begin
              st_r <= cht_pkg::ST_OK;
              idx_r <= hit_r;
              hgt_r <= hit_nh_r;
              hint_r <= hthint_r;
            end else begin
              hint_r <= fhit_any_r ? fhint_r : hthint_r;
              if (fhit_any_r) begin
                st_r <= cht_pkg::ST_OK;
                idx_r <= fhit_r;
                hgt_r <= hitf_nh_r;
              end
            end
          end
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_status = st_r;
  assign out_entry_index = idx_r;
  assign out_height_result = hgt_r;
  assign out_entry_count = 9'(count_r);
endmodule

>>> rtl/core/cht_checker.sv
// Port checker for checkpoint_height_table_unit, bound into that module.
// Depends on assert_macros.svh and cht_pkg.
`include "assert_macros.svh"
module cht_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [8:0] out_entry_count
);
  `CHT_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `CHT_ASSERT_IMP(a_valid_idle, clk, rst_n, out_valid, !busy)
  `CHT_ASSERT_NXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid)
  `CHT_ASSERT_IMP(a_status, clk, rst_n, out_valid, out_status <= cht_pkg::ST_NONE)
  `CHT_ASSERT_NXT(a_count_hold, clk, rst_n, !(start && !busy), $stable(out_entry_count))
endmodule

bind checkpoint_height_table_unit cht_checker u_cht_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_status(out_status),
  .out_entry_count(out_entry_count)
);
